// ===== hdl/bpc_pkg.sv =====
`timescale 1ns / 1ps
package bpc_pkg;

  localparam int RAW_W     = 20;
  localparam int DIV_STEPS = 64;
  localparam int DEN_W     = 31;
  localparam int ADDR_W    = 5;

  typedef enum logic [2:0] {
    REG_T1    = 3'd0,
    REG_T2    = 3'd1,
    REG_T3    = 3'd2,
    REG_P1    = 3'd3,
    REG_P2_P3 = 3'd4,
    REG_P4_P5 = 3'd5,
    REG_P6_P7 = 3'd6,
    REG_P8_P9 = 3'd7
  } reg_idx_t;

  // fields that ride alongside the divider
  typedef struct packed {
    logic [31:0] tc;
    logic [31:0] tf;
    logic        qneg;
    logic        invalid;
  } pass_t;

  // low 64 bits of a times an unsigned 16-bit word
  function automatic logic [63:0] mul_u16(input logic [63:0] a, input logic [15:0] b);
    logic [79:0] pr;
    begin
      pr = {16'b0, a} * {64'b0, b};
      return pr[63:0];
    end
  endfunction

  // low 64 bits of a times a two's complement 16-bit word
  function automatic logic [63:0] mul_s16(input logic [63:0] a, input logic [15:0] b);
    logic [79:0] pr;
    begin
      pr = {16'b0, a} * {64'b0, b};
      return pr[63:0] - (b[15] ? {a[47:0], 16'b0} : 64'b0);
    end
  endfunction

endpackage

// ===== hdl/bpc_div.sv =====
`timescale 1ns / 1ps
module bpc_div import bpc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [63:0]       in_num,
  input  logic [DEN_W-1:0]  in_den,
  input  pass_t             in_side,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [63:0]       out_quo,
  output pass_t             out_side
);

  // restoring division, one quotient bit per stage
  logic [DIV_STEPS-1:0] vld;
  logic [DIV_STEPS:0]   rdy;
  logic [63:0]          num [DIV_STEPS];
  logic [DEN_W-1:0]     rem [DIV_STEPS];
  logic [DEN_W-1:0]     den [DIV_STEPS];
  pass_t                side [DIV_STEPS];

  assign rdy[DIV_STEPS] = out_ready;

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_stage
    logic              v_in;
    logic [63:0]       n_in;
    logic [DEN_W-1:0]  r_in;
    logic [DEN_W-1:0]  d_in;
    pass_t             s_in;
    logic [DEN_W:0]    trial;
    logic              ge;

    if (k == 0) begin : g_first
      assign v_in = in_valid;
      assign n_in = in_num;
      assign r_in = '0;
      assign d_in = in_den;
      assign s_in = in_side;
    end else begin : g_rest
      assign v_in = vld[k-1];
      assign n_in = num[k-1];
      assign r_in = rem[k-1];
      assign d_in = den[k-1];
      assign s_in = side[k-1];
    end

    assign rdy[k] = !vld[k] || rdy[k+1];
    assign trial  = {r_in, n_in[63]};
    assign ge     = trial >= {1'b0, d_in};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (rdy[k]) begin
        vld[k] <= v_in;
      end
      if (rdy[k]) begin
        rem[k]  <= ge ? DEN_W'(trial - {1'b0, d_in}) : trial[DEN_W-1:0];
        num[k]  <= {n_in[62:0], ge};
        den[k]  <= d_in;
        side[k] <= s_in;
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = vld[DIV_STEPS-1];
  assign out_quo   = num[DIV_STEPS-1];
  assign out_side  = side[DIV_STEPS-1];

  a_rem_below_den: assert property (@(posedge clk) disable iff (rst)
    vld[DIV_STEPS-1] && den[DIV_STEPS-1] != '0 |-> rem[DIV_STEPS-1] < den[DIV_STEPS-1])
    else $error("remainder not below divisor");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_quo))
    else $error("quotient lost while stalled");

  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !vld[0] |-> in_ready)
    else $error("empty first stage refused an item");

endmodule

// ===== hdl/baro_temp_pressure_compensation_top.sv =====
`timescale 1ns / 1ps
// Pipeline from input acceptance to the result: 8 front stages, 64 divider stages,
// 6 back stages including the output register.
// Throughput: one item per cycle unless the output stalls; the 64-stage restoring divider
// sets the depth. A stall at the output backs up stage by stage; empty stages still fill.
// Reset: synchronous, clears all valid bits and the calibration registers to 0.
module baro_temp_pressure_compensation_top import bpc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [39:0]       s_tdata,   // raw_temperature[19:0], raw_pressure[39:20]
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [95:0]       m_tdata,   // temperature_centi, fine_temperature, pressure_q24_8
  output logic [0:0]        m_tuser,   // pressure_invalid
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  // calibration registers
  logic [15:0] cal_t1, cal_t2, cal_t3, cal_p1;
  logic [31:0] cal_p2_p3, cal_p4_p5, cal_p6_p7, cal_p8_p9;
  reg_idx_t    ridx;

  assign pready = 1'b1;
  assign ridx   = reg_idx_t'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_t1 <= '0; cal_t2 <= '0; cal_t3 <= '0; cal_p1 <= '0;
      cal_p2_p3 <= '0; cal_p4_p5 <= '0; cal_p6_p7 <= '0; cal_p8_p9 <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (ridx)
        REG_T1:    cal_t1    <= pwdata[15:0];
        REG_T2:    cal_t2    <= pwdata[15:0];
        REG_T3:    cal_t3    <= pwdata[15:0];
        REG_P1:    cal_p1    <= pwdata[15:0];
        REG_P2_P3: cal_p2_p3 <= pwdata;
        REG_P4_P5: cal_p4_p5 <= pwdata;
        REG_P6_P7: cal_p6_p7 <= pwdata;
        REG_P8_P9: cal_p8_p9 <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      REG_T1:    prdata = {16'b0, cal_t1};
      REG_T2:    prdata = {16'b0, cal_t2};
      REG_T3:    prdata = {16'b0, cal_t3};
      REG_P1:    prdata = {16'b0, cal_p1};
      REG_P2_P3: prdata = cal_p2_p3;
      REG_P4_P5: prdata = cal_p4_p5;
      REG_P6_P7: prdata = cal_p6_p7;
      REG_P8_P9: prdata = cal_p8_p9;
      default:   prdata = '0;
    endcase
  end

  // stage valids and enables
  logic v1, v2, v3, v4, v5, v6, v7, v8, vq, va, vb, vc, vd, ve;
  logic en1, en2, en3, en4, en5, en6, en7, en8, enq, ena, enb, enc, end_, ene;
  logic div_in_ready, div_out_valid;
  logic [63:0] div_quo;
  pass_t       div_side_in, div_side_out;

  assign ene  = !ve || m_tready;
  assign end_ = !vd || ene;
  assign enc  = !vc || end_;
  assign enb  = !vb || enc;
  assign ena  = !va || enb;
  assign enq  = !vq || ena;
  assign en8  = !v8 || div_in_ready;
  assign en7  = !v7 || en8;
  assign en6  = !v6 || en7;
  assign en5  = !v5 || en6;
  assign en4  = !v4 || en5;
  assign en3  = !v3 || en4;
  assign en2  = !v2 || en3;
  assign en1  = !v1 || en2;
  assign s_tready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; v5 <= 1'b0; v6 <= 1'b0;
      v7 <= 1'b0; v8 <= 1'b0; vq <= 1'b0; va <= 1'b0; vb <= 1'b0; vc <= 1'b0;
      vd <= 1'b0; ve <= 1'b0;
    end else begin
      if (en1) v1 <= s_tvalid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) v5 <= v4;
      if (en6) v6 <= v5;
      if (en7) v7 <= v6;
      if (en8) v8 <= v7;
      if (enq) vq <= div_out_valid;
      if (ena) va <= vq;
      if (enb) vb <= va;
      if (enc) vc <= vb;
      if (end_) vd <= vc;
      if (ene) ve <= vd;
    end
  end

  // stage 1: temperature differences and products
  logic [RAW_W-1:0]   rt_in, rp_in;
  logic signed [17:0] ta;
  logic signed [16:0] tb;
  logic signed [33:0] s1_ma, s1_mb;
  logic [RAW_W-1:0]   s1_rp;

  assign rt_in = s_tdata[19:0];
  assign rp_in = s_tdata[39:20];
  assign ta = $signed({1'b0, rt_in[19:3]}) - $signed({1'b0, cal_t1, 1'b0});
  assign tb = $signed({1'b0, rt_in[19:4]}) - $signed({1'b0, cal_t1});

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_ma <= ta * $signed(cal_t2);
      s1_mb <= tb * tb;
      s1_rp <= rp_in;
    end
  end

  // stage 2
  logic signed [22:0] s2_v1;
  logic signed [38:0] s2_pr;
  logic [RAW_W-1:0]   s2_rp;

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_v1 <= 23'(s1_ma >>> 11);
      s2_pr <= $signed({1'b0, s1_mb[33:12]}) * $signed(cal_t3);
      s2_rp <= s1_rp;
    end
  end

  // stage 3: fine temperature
  logic signed [31:0] s3_tf;
  logic [RAW_W-1:0]   s3_rp;

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_tf <= 32'(s2_v1) + 32'(s2_pr >>> 14);
      s3_rp <= s2_rp;
    end
  end

  // stage 4: centi-degrees, offset and square
  logic signed [34:0] t5;
  logic signed [23:0] dvc;
  logic signed [31:0] s4_tf, s4_tc;
  logic signed [23:0] s4_dv;
  logic signed [47:0] s4_sq;
  logic [RAW_W-1:0]   s4_rp;

  assign t5  = (35'(s3_tf) <<< 2) + 35'(s3_tf) + 35'sd128;
  assign dvc = 24'(s3_tf - 32'sd128000);

  always_ff @(posedge clk) begin
    if (en4) begin
      s4_tc <= 32'(t5 >>> 8);
      s4_tf <= s3_tf;
      s4_dv <= dvc;
      s4_sq <= dvc * dvc;
      s4_rp <= s3_rp;
    end
  end

  // stage 5: pressure offset and scale products
  logic [63:0]        s5_x6, s5_x5, s5_x3, s5_x2;
  logic signed [31:0] s5_tf, s5_tc;
  logic [RAW_W-1:0]   s5_rp;

  always_ff @(posedge clk) begin
    if (en5) begin
      s5_x6 <= mul_s16({16'b0, s4_sq}, cal_p6_p7[15:0]);
      s5_x3 <= mul_s16({16'b0, s4_sq}, cal_p2_p3[31:16]);
      s5_x5 <= mul_s16(64'(s4_dv), cal_p4_p5[31:16]) << 17;
      s5_x2 <= mul_s16(64'(s4_dv), cal_p2_p3[15:0]) << 12;
      s5_tf <= s4_tf;
      s5_tc <= s4_tc;
      s5_rp <= s4_rp;
    end
  end

  // stage 6
  logic [63:0]        s6_v2, s6_v1;
  logic signed [31:0] s6_tf, s6_tc;
  logic [RAW_W-1:0]   s6_rp;

  always_ff @(posedge clk) begin
    if (en6) begin
      s6_v2 <= s5_x6 + s5_x5 + ({{48{cal_p4_p5[15]}}, cal_p4_p5[15:0]} << 35);
      s6_v1 <= 64'($signed(s5_x3) >>> 8) + s5_x2;
      s6_tf <= s5_tf;
      s6_tc <= s5_tc;
      s6_rp <= s5_rp;
    end
  end

  // stage 7: divisor and dividend
  logic [63:0]        s7_pa, s7_num;
  logic signed [31:0] s7_tf, s7_tc;

  always_ff @(posedge clk) begin
    if (en7) begin
      s7_pa  <= mul_u16(64'h0000_8000_0000_0000 + s6_v1, cal_p1);
      s7_num <= mul_u16(({43'b0, 21'h100000 - {1'b0, s6_rp}} << 31) - s6_v2, 16'd3125);
      s7_tf  <= s6_tf;
      s7_tc  <= s6_tc;
    end
  end

  // stage 8: magnitudes and signs for the divider
  logic [DEN_W-1:0] dsg;
  logic [63:0]      s8_un;
  logic [DEN_W-1:0] s8_ud;
  pass_t            s8_side;

  assign dsg = DEN_W'($signed(s7_pa) >>> 33);

  always_ff @(posedge clk) begin
    if (en8) begin
      s8_un           <= s7_num[63] ? 64'b0 - s7_num : s7_num;
      s8_ud           <= dsg[DEN_W-1] ? DEN_W'(0) - dsg : dsg;
      s8_side.tc      <= s7_tc;
      s8_side.tf      <= s7_tf;
      s8_side.qneg    <= s7_num[63] ^ dsg[DEN_W-1];
      s8_side.invalid <= (dsg == '0);
    end
  end

  assign div_side_in = s8_side;

  bpc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v8),
    .in_ready  (div_in_ready),
    .in_num    (s8_un),
    .in_den    (s8_ud),
    .in_side   (div_side_in),
    .out_valid (div_out_valid),
    .out_ready (enq),
    .out_quo   (div_quo),
    .out_side  (div_side_out)
  );

  // stage q: signed quotient
  logic [63:0] sq_p;
  pass_t       sq_side;

  always_ff @(posedge clk) begin
    if (enq) begin
      sq_p    <= div_side_out.qneg ? 64'b0 - div_quo : div_quo;
      sq_side <= div_side_out;
    end
  end

  // stage a: square of p >> 13 in 32-bit halves, p8 term
  logic [63:0] pa13;
  logic [63:0] sa_ll, sa_p, sa_y8;
  logic [31:0] sa_hl;
  pass_t       sa_side;

  assign pa13 = 64'($signed(sq_p) >>> 13);

  always_ff @(posedge clk) begin
    if (ena) begin
      sa_ll   <= pa13[31:0] * pa13[31:0];
      sa_hl   <= 32'(pa13[63:32] * pa13[31:0]);
      sa_y8   <= mul_s16(sq_p, cal_p8_p9[15:0]);
      sa_p    <= sq_p;
      sa_side <= sq_side;
    end
  end

  // stage b
  logic [63:0] sb_aa, sb_p, sb_y8;
  pass_t       sb_side;

  always_ff @(posedge clk) begin
    if (enb) begin
      sb_aa   <= sa_ll + {sa_hl[30:0], 1'b0, 32'b0};
      sb_p    <= sa_p;
      sb_y8   <= sa_y8;
      sb_side <= sa_side;
    end
  end

  // stage c: p9 term
  logic [63:0] sc_y9, sc_p, sc_y8;
  pass_t       sc_side;

  always_ff @(posedge clk) begin
    if (enc) begin
      sc_y9   <= mul_s16(sb_aa, cal_p8_p9[31:16]);
      sc_p    <= sb_p;
      sc_y8   <= sb_y8;
      sc_side <= sb_side;
    end
  end

  // stage d
  logic [63:0] sd_s;
  pass_t       sd_side;

  always_ff @(posedge clk) begin
    if (end_) begin
      sd_s    <= sc_p + 64'($signed(sc_y9) >>> 25) + 64'($signed(sc_y8) >>> 19);
      sd_side <= sc_side;
    end
  end

  // stage e: output register
  logic [31:0] out_tc, out_tf, out_p;
  logic        out_inv;

  always_ff @(posedge clk) begin
    if (ene) begin
      out_tc  <= sd_side.tc;
      out_tf  <= sd_side.tf;
      out_inv <= sd_side.invalid;
      out_p   <= sd_side.invalid ? 32'b0 :
                 32'($signed(sd_s) >>> 8) +
                 ({{16{cal_p6_p7[31]}}, cal_p6_p7[31:16]} << 4);
    end
  end

  assign m_tvalid = ve;
  assign m_tdata  = {out_p, out_tf, out_tc};
  assign m_tuser  = out_inv;

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata[95:64] == 32'b0)
    else $error("invalid pressure not zero");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input refused with empty output register");

  a_reset_clears: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result valid straight after reset");

endmodule

// ===== dv/baro_comp_checker.sv =====
`timescale 1ns / 1ps
module baro_comp_checker import bpc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  input  logic              s_tready,
  input  logic [39:0]       s_tdata,   // raw_temperature[19:0], raw_pressure[39:20]
  input  logic              m_tvalid,
  input  logic              m_tready,
  input  logic [95:0]       m_tdata,   // temperature_centi, fine_temperature, pressure_q24_8
  input  logic [0:0]        m_tuser,   // pressure_invalid
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output int                fail_count,
  output int                pending,
  output int                checked,
  output int                invalid_seen
);

  typedef struct packed {
    logic [31:0] temp_centi;
    logic [31:0] fine_temp;
    logic [31:0] press_q24_8;
    logic        press_invalid;
  } comp_result_t;

  comp_result_t expected_results[$];
  logic [15:0] t1, t2, t3, p1;
  logic [31:0] p23, p45, p67, p89;

  function automatic logic [63:0] sext16(input logic [15:0] w);
    return {{48{w[15]}}, w};
  endfunction

  function automatic logic [63:0] sra(input logic [63:0] v, input int n);
    return $signed(v) >>> n;
  endfunction

  // signed 64-bit division, truncating toward zero
  function automatic logic [63:0] div_trunc(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] un, ud, q;
    un = n[63] ? -n : n;
    ud = d[63] ? -d : d;
    q  = un / ud;
    return (n[63] != d[63]) ? -q : q;
  endfunction

  function automatic comp_result_t compensate(input logic [19:0] raw_t,
                                              input logic [19:0] raw_p);
    logic [63:0] rt, rp, ct1, ct2, ct3, cp1, cp2, cp3, cp4, cp5, cp6, cp7, cp8, cp9;
    logic [63:0] a, b, v1, v2, tf, tc, p, sq;
    comp_result_t r;
    rt = {44'b0, raw_t};
    rp = {44'b0, raw_p};
    ct1 = {48'b0, t1};
    ct2 = sext16(t2);
    ct3 = sext16(t3);
    cp1 = {48'b0, p1};
    cp2 = sext16(p23[15:0]); cp3 = sext16(p23[31:16]);
    cp4 = sext16(p45[15:0]); cp5 = sext16(p45[31:16]);
    cp6 = sext16(p67[15:0]); cp7 = sext16(p67[31:16]);
    cp8 = sext16(p89[15:0]); cp9 = sext16(p89[31:16]);
    r.press_invalid = 1'b0;

    a  = (rt >> 3) - (ct1 << 1);
    v1 = sra(a * ct2, 11);
    b  = (rt >> 4) - ct1;
    sq = sra(b * b, 12);
    v2 = sra(sq * ct3, 14);
    tf = v1 + v2;
    tc = sra(tf * 64'd5 + 64'd128, 8);

    v1 = tf - 64'd128000;
    v2 = v1 * v1 * cp6;
    v2 = v2 + ((v1 * cp5) << 17);
    v2 = v2 + (cp4 << 35);
    v1 = sra(v1 * v1 * cp3, 8) + ((v1 * cp2) << 12);
    v1 = sra(((64'd1 << 47) + v1) * cp1, 33);
    if (v1 == 64'd0) begin
      p = 64'd0;
      r.press_invalid = 1'b1;
    end else begin
      p  = 64'd1048576 - rp;
      p  = div_trunc(((p << 31) - v2) * 64'd3125, v1);
      a  = sra(p, 13);
      v1 = sra(cp9 * a * a, 25);
      v2 = sra(cp8 * p, 19);
      p  = sra(p + v1 + v2, 8) + (cp7 << 4);
    end
    r.temp_centi  = tc[31:0];
    r.fine_temp   = tf[31:0];
    r.press_q24_8 = p[31:0];
    return r;
  endfunction

  always @(posedge clk) begin
    comp_result_t exp_r;
    int errs;
    errs = 0;
    if (rst) begin
      t1 <= '0; t2 <= '0; t3 <= '0; p1 <= '0;
      p23 <= '0; p45 <= '0; p67 <= '0; p89 <= '0;
      expected_results.delete();
      fail_count <= 0;
      checked <= 0;
      invalid_seen <= 0;
      pending <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[4:2]))
          REG_T1:    t1  <= pwdata[15:0];
          REG_T2:    t2  <= pwdata[15:0];
          REG_T3:    t3  <= pwdata[15:0];
          REG_P1:    p1  <= pwdata[15:0];
          REG_P2_P3: p23 <= pwdata;
          REG_P4_P5: p45 <= pwdata;
          REG_P6_P7: p67 <= pwdata;
          REG_P8_P9: p89 <= pwdata;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready)
        expected_results.push_back(compensate(s_tdata[19:0], s_tdata[39:20]));
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          $error("result with nothing expected: %h %b", m_tdata, m_tuser);
          errs++;
        end else begin
          exp_r = expected_results.pop_front();
          checked <= checked + 1;
          if (exp_r.press_invalid) invalid_seen <= invalid_seen + 1;
          if (m_tdata[31:0] !== exp_r.temp_centi) begin
            $error("temperature_centi: expected %h, got %h", exp_r.temp_centi, m_tdata[31:0]);
            errs++;
          end
          if (m_tdata[63:32] !== exp_r.fine_temp) begin
            $error("fine_temperature: expected %h, got %h", exp_r.fine_temp, m_tdata[63:32]);
            errs++;
          end
          if (m_tdata[95:64] !== exp_r.press_q24_8) begin
            $error("pressure_q24_8: expected %h, got %h", exp_r.press_q24_8,
                   m_tdata[95:64]);
            errs++;
          end
          if (m_tuser[0] !== exp_r.press_invalid) begin
            $error("pressure_invalid: expected %b, got %b", exp_r.press_invalid, m_tuser[0]);
            errs++;
          end
        end
      end
      if (errs != 0) fail_count <= fail_count + errs;
      pending <= expected_results.size();
    end
  end

endmodule

// ===== dv/baro_temp_pressure_compensation_top_tb.sv =====
`timescale 1ns / 1ps
module baro_temp_pressure_compensation_top_tb;
  import bpc_pkg::*;

  localparam int IDLE_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 100;

  logic              clk, rst;
  logic              s_tvalid, s_tready;
  logic [39:0]       s_tdata;
  logic              m_tvalid, m_tready;
  logic [95:0]       m_tdata;
  logic [0:0]        m_tuser;
  logic              psel, penable, pwrite, pready;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]       pwdata, prdata;
  int                fail_count, pending, checked, invalid_seen;
  int                sent, idle_cycles;
  bit                hold_off_req;

  baro_temp_pressure_compensation_top dut (.*);

  baro_comp_checker u_checker (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready, .m_tdata,
    .m_tuser, .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .fail_count, .pending, .checked, .invalid_seen
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic apb_write(input reg_idx_t idx, input logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= ADDR_W'(idx) << 2; pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic load_cal(input logic [15:0] ct1, ct2, ct3, cp1,
                          input logic [31:0] c23, c45, c67, c89);
    apb_write(REG_T1, {16'hA5A5, ct1});
    apb_write(REG_T2, {16'h5A5A, ct2});
    apb_write(REG_T3, {16'hFFFF, ct3});
    apb_write(REG_P1, {16'h0000, cp1});
    apb_write(REG_P2_P3, c23);
    apb_write(REG_P4_P5, c45);
    apb_write(REG_P6_P7, c67);
    apb_write(REG_P8_P9, c89);
  endtask

  // called at a falling edge; returns at a falling edge after acceptance
  task automatic send_raw(input logic [19:0] raw_t, input logic [19:0] raw_p);
    int gap, r;
    r = $urandom_range(0, 19);
    gap = (r < 13) ? 0 : (r < 19) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {raw_p, raw_t};
    do @(posedge clk); while (!s_tready);
    sent++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic random_items(input int n, input bit near_real);
    logic [19:0] rt, rp;
    repeat (n) begin
      if (near_real) begin
        rt = 20'($urandom_range(400000, 600000));
        rp = 20'($urandom_range(200000, 500000));
      end else begin
        rt = 20'($urandom);
        rp = 20'($urandom);
      end
      if ($urandom_range(0, 9) == 0) rt = ($urandom_range(0, 1)) ? 20'hFFFFF : 20'h0;
      if ($urandom_range(0, 9) == 0) rp = ($urandom_range(0, 1)) ? 20'hFFFFF : 20'h0;
      send_raw(rt, rp);
    end
  endtask

  // receiver: random ready, and one long hold-off when asked
  initial begin
    int r, len;
    m_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_off_req) begin
        m_tready <= 1'b0;
        repeat (400) @(negedge clk);
        hold_off_req = 1'b0;
      end else begin
        r = $urandom_range(0, 9);
        if (r < 6) begin
          m_tready <= 1'b1; len = $urandom_range(1, 25);
        end else if (r < 9) begin
          m_tready <= 1'b0; len = $urandom_range(1, 3);
        end else begin
          m_tready <= 1'b0; len = $urandom_range(10, 40);
        end
        repeat (len) @(negedge clk);
      end
    end
  end

  // watchdog on cycles with no accepted item on either side and no APB access
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("baro_temp_pressure_compensation_top_tb: FAIL");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0; s_tdata = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    hold_off_req = 1'b0;
    sent = 0; idle_cycles = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset calibration: P1 is zero, so every pressure is flagged invalid
    send_raw(20'h0, 20'h0);
    send_raw(20'hFFFFF, 20'hFFFFF);
    random_items(20, 1'b0);
    wait_idle();

    // typical calibration words
    load_cal(16'd27504, 16'd26435, -16'sd1000, 16'd36477,
             {16'd3024, -16'sd10685}, {16'd140, 16'd2855},
             {16'd15500, -16'sd7}, {16'd6000, -16'sd14600});
    send_raw(20'h0, 20'h0);
    send_raw(20'hFFFFF, 20'h0);
    send_raw(20'h0, 20'hFFFFF);
    send_raw(20'd519888, 20'd415148);
    hold_off_req = 1'b1;
    random_items(300, 1'b1);
    random_items(100, 1'b0);
    wait_idle();

    // all ones
    load_cal(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
             32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
    send_raw(20'h0, 20'hFFFFF);
    send_raw(20'hFFFFF, 20'h0);
    random_items(30, 1'b0);
    wait_idle();

    // most negative / largest positive words
    load_cal(16'h0000, 16'h8000, 16'h7FFF, 16'h0001,
             32'h80007FFF, 32'h7FFF8000, 32'h80008000, 32'h7FFF7FFF);
    send_raw(20'h0, 20'h0);
    send_raw(20'hFFFFF, 20'hFFFFF);
    random_items(30, 1'b0);
    wait_idle();

    // random calibration sets, P1 sometimes zero
    repeat (10) begin
      load_cal(16'($urandom), 16'($urandom), 16'($urandom),
               ($urandom_range(0, 4) == 0) ? 16'h0 : 16'($urandom),
               $urandom, $urandom, $urandom, $urandom);
      random_items(45, 1'b0);
      wait_idle();
    end

    $display("Covered %0d items over reset, typical, extreme and random calibrations;",
             sent);
    $display("%0d results checked, %0d with the pressure divisor at zero.",
             checked, invalid_seen);
    if (fail_count == 0)
      $display("baro_temp_pressure_compensation_top_tb: PASS");
    else
      $display("baro_temp_pressure_compensation_top_tb: FAIL");
    $finish;
  end

endmodule
